>>> src/sequence_reorder_buffer_gap_fill_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sequence reorder buffer
// Concurrent assertion wrappers; they compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_GAP_FILL_ASSERT_SVH
`define SEQUENCE_REORDER_BUFFER_GAP_FILL_ASSERT_SVH
`ifndef ASSERT_OFF
`define SRBGF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SRBGF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SRBGF_ASSERT(lbl, clk, rstn, prop, msg)
`define SRBGF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> src/srbgf_pkg.sv
// ----------------------------------------------------------------------------
// srbgf_pkg
// Shared types and constants of the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srbgf_pkg;

  localparam int IdW  = 32;
  localparam int TagW = 16;
  localparam int ThrW = 6;

  // Result status codes.
  localparam logic [1:0] StInOrder = 2'd0;
  localparam logic [1:0] StFiller  = 2'd1;
  localparam logic [1:0] StLate    = 2'd2;
  localparam logic [1:0] StBeyond  = 2'd3;

  localparam logic [ThrW-1:0] GapThreshReset = 6'd50;

  // Register index as seen on paddr[2].
  localparam logic RegGapThresh = 1'b0;

  // Request kinds.
  localparam logic ReqFrame = 1'b0;
  localparam logic ReqTick  = 1'b1;

  typedef struct packed {
    logic            is_tick;
    logic [IdW-1:0]  seq_id;
    logic [TagW-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [TagW-1:0] tag;
    logic [1:0]      status;
  } res_t;

endpackage

>>> src/srbgf_front.sv
// ----------------------------------------------------------------------------
// srbgf_front
// Input side: takes items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module srbgf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic [srbgf_pkg::IdW-1:0]  frame_id_i,
  input  logic [srbgf_pkg::TagW-1:0] payload_tag_i,
  output logic                      cmd_valid_o,
  output srbgf_pkg::cmd_t           cmd_o,
  input  logic                      cmd_pop_i
);

  srbgf_pkg::cmd_t ent_q [2];
  srbgf_pkg::cmd_t new_cmd;
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    new_cmd.is_tick = (req_type_i == srbgf_pkg::ReqTick);
    new_cmd.seq_id  = frame_id_i;
    new_cmd.tag     = payload_tag_i;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> src/srbgf_engine.sv
// ----------------------------------------------------------------------------
// srbgf_engine
// Back side: window store, in-order drain, gap fill and result staging.
// ----------------------------------------------------------------------------
`include "sequence_reorder_buffer_gap_fill_assert.svh"

module srbgf_engine #(
  parameter int WINDOW = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [srbgf_pkg::ThrW-1:0] gap_thresh_i,
  input  logic                       cmd_valid_i,
  input  srbgf_pkg::cmd_t            cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output srbgf_pkg::res_t            out_o,
  output logic                       out_last_o
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [IW:0]                 WinExt   = (IW + 1)'(WINDOW);
  localparam logic [srbgf_pkg::IdW-1:0]   Win32    = srbgf_pkg::IdW'(WINDOW);
  localparam logic [IW-1:0]               LastSlot = IW'(WINDOW - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_GAP   = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [srbgf_pkg::IdW-1:0]    ne_q, ne_d;
  logic [IW-1:0]                ne_slot_q, ne_slot_d;
  logic [srbgf_pkg::IdW-1:0]    hh_q, hh_d;
  logic [CW-1:0]                held_q, held_d;
  logic [WINDOW-1:0]            slot_valid_q, slot_valid_d;

  logic [srbgf_pkg::TagW-1:0]   tag_mem_q [WINDOW];
  logic [srbgf_pkg::TagW-1:0]   rdata_q;
  logic                         mem_we, mem_re;
  logic [IW-1:0]                mem_waddr, mem_raddr;
  logic [srbgf_pkg::TagW-1:0]   mem_wdata;

  logic                         rdv_q, rdv_d;
  logic [srbgf_pkg::IdW-1:0]    rd_id_q, rd_id_d;

  logic                         pend_valid_q, pend_valid_d;
  srbgf_pkg::res_t              pend_q, pend_d;
  logic                         out_valid_q, out_valid_d;
  srbgf_pkg::res_t              out_q, out_d;
  logic                         out_last_q, out_last_d;

  logic                         out_free, can_push, push, finish;
  srbgf_pkg::res_t              push_res;
  logic [srbgf_pkg::IdW-1:0]    id_ahead, gap;
  logic                         in_win;
  logic [IW:0]                  slot_sum;
  logic [IW-1:0]                ins_slot, ne_slot_inc;

  assign out_free = !out_valid_q || out_ready_i;
  assign can_push = !pend_valid_q || out_free;
  assign id_ahead = cmd_i.seq_id - ne_q;
  assign in_win   = (id_ahead < Win32);
  assign gap      = hh_q - ne_q;

  // The slot of an in-window id follows from the expected slot plus the distance,
  // so no modulo by the window size is needed.
  assign slot_sum    = {1'b0, ne_slot_q} + {1'b0, id_ahead[IW-1:0]};
  assign ins_slot    = (slot_sum >= WinExt) ? IW'(slot_sum - WinExt) : slot_sum[IW-1:0];
  assign ne_slot_inc = (ne_slot_q == LastSlot) ? '0 : ne_slot_q + IW'(1);

  always_comb begin
    state_d      = state_q;
    ne_d         = ne_q;
    ne_slot_d    = ne_slot_q;
    hh_d         = hh_q;
    held_d       = held_q;
    slot_valid_d = slot_valid_q;
    rdv_d        = rdv_q;
    rd_id_d      = rd_id_q;
    mem_we       = 1'b0;
    mem_waddr    = ins_slot;
    mem_wdata    = cmd_i.tag;
    mem_re       = 1'b0;
    mem_raddr    = ne_slot_q;
    push         = 1'b0;
    push_res     = '0;
    finish       = 1'b0;
    cmd_pop_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_tick) begin
            state_d = S_GAP;
          end else begin
            state_d = S_DRAIN;
            if (!in_win) begin
              push            = 1'b1;
              push_res.id     = cmd_i.seq_id;
              push_res.tag    = cmd_i.tag;
              push_res.status = (cmd_i.seq_id < ne_q) ? srbgf_pkg::StLate
                                                      : srbgf_pkg::StBeyond;
            end else begin
              // A duplicate only overwrites the stored tag.
              mem_we                 = 1'b1;
              slot_valid_d[ins_slot] = 1'b1;
              if (!slot_valid_q[ins_slot]) begin
                held_d = held_q + CW'(1);
                if (held_q == '0 || id_ahead > gap) begin
                  hh_d = cmd_i.seq_id;
                end
              end
            end
          end
        end
      end
      S_DRAIN: begin
        // One tag read is in flight at a time; its result is staged as the next read issues.
        if (!rdv_q || can_push) begin
          if (rdv_q) begin
            push            = 1'b1;
            push_res.id     = rd_id_q;
            push_res.tag    = rdata_q;
            push_res.status = srbgf_pkg::StInOrder;
          end
          if (slot_valid_q[ne_slot_q]) begin
            mem_re                  = 1'b1;
            rdv_d                   = 1'b1;
            rd_id_d                 = ne_q;
            slot_valid_d[ne_slot_q] = 1'b0;
            held_d                  = held_q - CW'(1);
            ne_d                    = ne_q + 32'd1;
            ne_slot_d               = ne_slot_inc;
          end else begin
            rdv_d   = 1'b0;
            state_d = S_GAP;
          end
        end
      end
      S_GAP: begin
        if (held_q != '0 && gap > {{(srbgf_pkg::IdW - srbgf_pkg::ThrW){1'b0}}, gap_thresh_i}) begin
          state_d = S_FILL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        if (ne_q != hh_q && !slot_valid_q[ne_slot_q]) begin
          if (can_push) begin
            push            = 1'b1;
            push_res.id     = ne_q;
            push_res.tag    = '0;
            push_res.status = srbgf_pkg::StFiller;
            ne_d            = ne_q + 32'd1;
            ne_slot_d       = ne_slot_inc;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A result waits in the pending stage until it is known whether it is the last one.
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    out_last_d   = out_last_q;
    if (push) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_d       = push_res;
    end
    if (finish) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= tag_mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_id_q    <= rd_id_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ne_q         <= '0;
      ne_slot_q    <= '0;
      hh_q         <= '0;
      held_q       <= '0;
      slot_valid_q <= '0;
      rdv_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ne_q         <= ne_d;
      ne_slot_q    <= ne_slot_d;
      hh_q         <= hh_d;
      held_q       <= held_d;
      slot_valid_q <= slot_valid_d;
      rdv_q        <= rdv_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_last_o  = out_last_q;

  `SRBGF_ASSERT(a_held_matches_valid, clk_i, rst_ni, ($countones(slot_valid_q) == int'(held_q)), "held count disagrees with valid bits")
  `SRBGF_ASSERT_NEVER(a_idle_no_pending, clk_i, rst_ni, (state_q == S_IDLE && pend_valid_q), "pending result left behind at idle")
  `SRBGF_ASSERT(a_expected_steps_by_one, clk_i, rst_ni, ((ne_q == $past(ne_q)) || (ne_q == $past(ne_q) + 32'd1)), "expected id jumped")
  `SRBGF_ASSERT_NEVER(a_no_read_outside_drain, clk_i, rst_ni, (rdv_q && state_q != S_DRAIN), "tag read outstanding outside drain")

endmodule

>>> src/sequence_reorder_buffer_gap_fill.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_gap_fill
// Reorders tagged frames by sequence number and fills long gaps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: a frame arrival
//   (req_type_i = 0) with frame_id_i and payload_tag_i, or a tick (req_type_i = 1).
//   Output channel (out_valid_o/out_ready_i) carries the results of each item
//   in order, last_o marking the final result of an item; an item may cause none.
//   gap_threshold sits at APB address 0 and may be changed only while idle.
// Timing:
//   A two-entry queue takes items while the engine works. The drain and fill
//   sequencer handles one result per cycle out of the tag memory while the
//   output is not stalled, and it finishes one item before it takes the next.
//   A result passes the pending stage and then the output register; an
//   in-order result is first read out of the tag memory.
// Reset and stalls: reset clears the expected id, the held count and all slot
//   valid bits at once. A stalled receiver holds the output register, then the
//   sequencer, and the queue fills and drops in_ready_o.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_gap_fill #(
  parameter int WINDOW = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic [srbgf_pkg::IdW-1:0]  frame_id_i,
  input  logic [srbgf_pkg::TagW-1:0] payload_tag_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [srbgf_pkg::IdW-1:0]  out_id_o,
  output logic [srbgf_pkg::TagW-1:0] out_tag_o,
  output logic [1:0]                 status_o,
  output logic                       last_o
);

  logic [srbgf_pkg::ThrW-1:0] thr_q, thr_d;
  logic                       cfg_we;
  logic                       cmd_valid, cmd_pop;
  srbgf_pkg::cmd_t            cmd;
  srbgf_pkg::res_t            res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == srbgf_pkg::RegGapThresh);
  assign thr_d  = cfg_we ? pwdata[srbgf_pkg::ThrW-1:0] : thr_q;
  assign prdata = (paddr[2] == srbgf_pkg::RegGapThresh)
                ? {{(32 - srbgf_pkg::ThrW){1'b0}}, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= srbgf_pkg::GapThreshReset;
    end else begin
      thr_q <= thr_d;
    end
  end

  srbgf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .frame_id_i    (frame_id_i),
    .payload_tag_i (payload_tag_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  srbgf_engine #(
    .WINDOW (WINDOW)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gap_thresh_i (thr_q),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (res),
    .out_last_o   (last_o)
  );

  assign out_id_o  = res.id;
  assign out_tag_o = res.tag;
  assign status_o  = res.status;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sequence reorder buffer. A short table of
// directed items runs first. Random phases follow, each under its own gap
// threshold. Every item is predicted by a cycle-free model of the window
// state, and each result is checked against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned Win           = 64;
  localparam int          NumPhases     = 5;
  localparam int          PhaseItems    = 29;
  localparam int          SettleCycles  = 100;
  localparam int          HoldOffCycles = 400;
  localparam int          WatchdogLimit = 3000;

  typedef struct packed {
    logic [srbgf_pkg::IdW-1:0]  id;
    logic [srbgf_pkg::TagW-1:0] tag;
    logic [1:0]                 status;
    logic                       last;
  } seq_result_t;

  typedef struct {
    logic                       kind;
    logic [srbgf_pkg::IdW-1:0]  id;
    logic [srbgf_pkg::TagW-1:0] tag;
    bit                         typed;
    seq_result_t                res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                       in_valid_i    = 1'b0;
  logic                       in_ready_o;
  logic                       req_type_i    = srbgf_pkg::ReqFrame;
  logic [srbgf_pkg::IdW-1:0]  frame_id_i    = '0;
  logic [srbgf_pkg::TagW-1:0] payload_tag_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i   = 1'b0;
  logic [srbgf_pkg::IdW-1:0]  out_id_o;
  logic [srbgf_pkg::TagW-1:0] out_tag_o;
  logic [1:0]                 status_o;
  logic                       last_o;

  sequence_reorder_buffer_gap_fill u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .frame_id_i    (frame_id_i),
    .payload_tag_i (payload_tag_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_id_o      (out_id_o),
    .out_tag_o     (out_tag_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // Window state of the predictor.
  logic [srbgf_pkg::IdW-1:0]  next_exp;
  logic                       slot_vld [Win];
  logic [srbgf_pkg::TagW-1:0] slot_tag [Win];
  int unsigned                held_cnt;
  logic [srbgf_pkg::IdW-1:0]  highest;
  logic [srbgf_pkg::ThrW-1:0] gap_thr;

  seq_result_t step_results[$];
  seq_result_t expected_results[$];

  bit idle_on      = 1'b1;
  bit hold_off_req = 1'b0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void emit_result(input logic [srbgf_pkg::IdW-1:0] id,
                                      input logic [srbgf_pkg::TagW-1:0] tag,
                                      input logic [1:0] st);
    seq_result_t r;
    // One item never yields more than a window's worth of results.
    if (step_results.size() < Win) begin
      r.id     = id;
      r.tag    = tag;
      r.status = st;
      r.last   = 1'b0;
      step_results.push_back(r);
    end
  endfunction

  function automatic void reorder_predict(input logic kind,
                                          input logic [srbgf_pkg::IdW-1:0] id,
                                          input logic [srbgf_pkg::TagW-1:0] tag);
    logic [srbgf_pkg::IdW-1:0] ahead;
    logic [5:0]                s;
    step_results.delete();
    if (kind == srbgf_pkg::ReqFrame) begin
      ahead = id - next_exp;
      if (ahead >= Win) begin
        emit_result(id, tag, (id < next_exp) ? srbgf_pkg::StLate : srbgf_pkg::StBeyond);
      end else begin
        // The slot is the id modulo the window depth.
        s = id[5:0];
        if (!slot_vld[s]) begin
          slot_vld[s] = 1'b1;
          if (held_cnt == 0 || ahead > highest - next_exp) highest = id;
          held_cnt++;
        end
        slot_tag[s] = tag;
      end
      while (slot_vld[next_exp[5:0]]) begin
        emit_result(next_exp, slot_tag[next_exp[5:0]], srbgf_pkg::StInOrder);
        slot_vld[next_exp[5:0]] = 1'b0;
        held_cnt--;
        next_exp++;
      end
    end
    if (held_cnt > 0 && (highest - next_exp) > {26'd0, gap_thr}) begin
      while (next_exp != highest && !slot_vld[next_exp[5:0]]) begin
        emit_result(next_exp, '0, srbgf_pkg::StFiller);
        next_exp++;
      end
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && addr[2] == srbgf_pkg::RegGapThresh) gap_thr = wdata[srbgf_pkg::ThrW-1:0];
    @(posedge clk_i);
  endtask

  task automatic check_thresh_readback();
    logic [31:0] rd;
    apb_access(1'b0, 3'd0, '0, rd);
    if (rd !== {26'd0, gap_thr}) begin
      fail_count++;
      $display("%0t: gap_threshold readback expected %0d, actual %0d", $time, gap_thr, rd);
    end
  endtask

  // Drops valid after the last accepted item and lets the block go idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic offer_item(input logic kind, input logic [srbgf_pkg::IdW-1:0] id,
                            input logic [srbgf_pkg::TagW-1:0] tag, input bit typed,
                            input seq_result_t typed_res);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 10)) : 0;
    reorder_predict(kind, id, tag);
    if (typed) begin
      expected_results.push_back(typed_res);
    end else begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    frame_id_i    <= id;
    payload_tag_i <= tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  initial begin : receiver
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      gap = idle_on ? int'($urandom_range(0, 10)) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    seq_result_t want;
    seq_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{out_id_o, out_tag_o, status_o, last_o};
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result id %h tag %h status %0d last %0d",
                 $time, got.id, got.tag, got.status, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got.id !== want.id || got.tag !== want.tag || got.status !== want.status ||
            got.last !== want.last) begin
          fail_count++;
          $display("%0t: result mismatch expected id %h tag %h status %0d last %0d, %s",
                   $time, want.id, want.tag, want.status, want.last,
                   $sformatf("actual id %h tag %h status %0d last %0d",
                             got.id, got.tag, got.status, got.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog, no item moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t                   dir_rows[$];
    logic [srbgf_pkg::ThrW-1:0] phase_thr [NumPhases];
    logic [31:0]                rd;
    logic [31:0]                wdata;
    logic                       kind;
    logic [srbgf_pkg::IdW-1:0]  fid;
    logic [srbgf_pkg::TagW-1:0] ptag;
    int                         roll;

    next_exp = '0;
    held_cnt = 0;
    highest  = '0;
    gap_thr  = srbgf_pkg::GapThreshReset;
    foreach (slot_vld[i]) begin
      slot_vld[i] = 1'b0;
      slot_tag[i] = '0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_thresh_readback();

    // Directed rows under the reset threshold. Typed results follow directly
    // from the state: first frame, late and beyond-window drops.
    dir_rows.push_back('{srbgf_pkg::ReqTick,  32'd0,         16'h0000, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd0,         16'hFFFF, 1'b1,
                         '{32'd0, 16'hFFFF, srbgf_pkg::StInOrder, 1'b1}});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd0,         16'h1234, 1'b1,
                         '{32'd0, 16'h1234, srbgf_pkg::StLate, 1'b1}});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'hFFFF_FFFF, 16'h0000, 1'b1,
                         '{32'hFFFF_FFFF, 16'h0000, srbgf_pkg::StBeyond, 1'b1}});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd65,        16'hAAAA, 1'b1,
                         '{32'd65, 16'hAAAA, srbgf_pkg::StBeyond, 1'b1}});
    // Last slot of the window: a full run of fillers, then 64 is held back.
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd64,        16'h5555, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqTick,  32'd0,         16'h0000, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd67,        16'h0003, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd67,        16'h0033, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd66,        16'h0002, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd65,        16'h0001, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd66,        16'h7777, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd131,       16'hFFFF, 1'b0, '0});
    // A drop that is followed by the release of the frame left after fillers.
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'd195,       16'h00FF, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqFrame, 32'hFFFF_FFC0, 16'hFF00, 1'b0, '0});
    dir_rows.push_back('{srbgf_pkg::ReqTick,  32'hDEAD_BEEF, 16'hBEEF, 1'b0, '0});

    foreach (dir_rows[i])
      offer_item(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].tag, dir_rows[i].typed,
                 dir_rows[i].res);

    phase_thr[0] = 6'd0;
    phase_thr[1] = 6'd63;
    phase_thr[2] = 6'd1;
    phase_thr[3] = 6'($urandom_range(2, 62));
    phase_thr[4] = srbgf_pkg::GapThreshReset;

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      // Upper data bits are junk on one write; only the low bits are kept.
      wdata = (p == 3) ? {26'($urandom), phase_thr[p]} : {26'd0, phase_thr[p]};
      apb_access(1'b1, 3'd0, wdata, rd);
      // An address with no register behind it must leave the threshold alone.
      if (p == 1) apb_access(1'b1, 3'd4, $urandom, rd);
      check_thresh_readback();
      idle_on = (p != 1 && p != 3);
      if (p == 2) hold_off_req = 1'b1;

      for (int k = 0; k < PhaseItems; k++) begin
        roll = int'($urandom_range(0, 99));
        kind = srbgf_pkg::ReqFrame;
        ptag = 16'($urandom);
        if (roll < 10) begin
          kind = srbgf_pkg::ReqTick;
          fid  = $urandom;
        end else if (roll < 18 && next_exp != 0) begin
          fid = $urandom_range(0, next_exp - 1);
        end else if (roll < 22) begin
          fid = next_exp + Win + $urandom_range(0, 200);
        end else if (roll < 26) begin
          fid = $urandom;
        end else if (roll < 80) begin
          fid = next_exp + $urandom_range(0, 7);
        end else begin
          fid = next_exp + $urandom_range(0, Win - 1);
        end
        offer_item(kind, fid, ptag, 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
